// File: src/dvd_sector_audio_bitrate_probe_macros.svh
// ----------------------------------------------------------------------------
// DVD sector audio bitrate probe assertion macros
// Shared concurrent assertion forms for the probe checkers.
// ----------------------------------------------------------------------------
`ifndef DVD_SECTOR_AUDIO_BITRATE_PROBE_MACROS_SVH
`define DVD_SECTOR_AUDIO_BITRATE_PROBE_MACROS_SVH

// check while out of reset
`define DSABP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check at every edge, reset included
`define DSABP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: src/dsabp_pkg.sv
// ----------------------------------------------------------------------------
// DVD sector audio bitrate probe package
// Types, sector offsets and bitrate tables shared by the probe files.
// ----------------------------------------------------------------------------
package dsabp_pkg;

    localparam int W_BYTE  = 8;
    localparam int W_POS   = 12;
    localparam int W_RATE  = 22;
    localparam int W_CLASS = 3;
    localparam int W_KBPS  = 12;

    localparam logic [W_POS-1:0] POS_MAX      = 12'd4095;
    localparam logic [W_POS-1:0] POS_PACK_ID  = 12'd17;
    localparam logic [W_POS-1:0] POS_HDR_LEN  = 12'd22;
    localparam logic [W_POS-1:0] OFS_SUB_ID   = 12'd23;
    localparam logic [W_POS-1:0] OFS_AC3_PTR  = 12'd26;
    localparam logic [W_POS-1:0] OFS_DTS_HI   = 12'd35;
    localparam logic [W_POS-1:0] OFS_DTS_LO   = 12'd36;
    localparam logic [W_POS-1:0] AC3_RATE_OFS = 12'd4;

    localparam logic [W_BYTE-1:0] PRIVATE_STREAM_1 = 8'hBD;
    localparam logic [W_BYTE-1:0] AC3_SYNC_HI      = 8'h0B;
    localparam logic [W_BYTE-1:0] AC3_SYNC_LO      = 8'h77;
    localparam logic [W_BYTE-1:0] MPA_SYNC_BYTE    = 8'hFF;
    localparam logic [3:0]        MPA_SYNC_NIBBLE  = 4'hF;

    localparam logic [W_RATE-1:0] LPCM_RATE_RESET = 22'd2000000;
    localparam logic [W_RATE-1:0] DTS_KBIT_SCALE  = 22'd1000;

    typedef enum logic [W_CLASS-1:0] {
        CLS_UNKNOWN    = 3'd0,
        CLS_MPEG_VIDEO = 3'd1,
        CLS_MPEG_AUDIO = 3'd2,
        CLS_AC3        = 3'd3,
        CLS_DTS        = 3'd4,
        CLS_LPCM       = 3'd5,
        CLS_SUBPICTURE = 3'd6
    } t_stream_class;

    typedef enum logic [1:0] {
        MPA_SEARCH = 2'd0,
        MPA_RATE   = 2'd1,
        MPA_FOUND  = 2'd2
    } t_mpa_stage;

    localparam logic [W_KBPS-1:0] AC3_KBPS [32] = '{
        12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd80, 12'd96, 12'd112,
        12'd128, 12'd160, 12'd192, 12'd224, 12'd256, 12'd320, 12'd384, 12'd448,
        12'd512, 12'd576, 12'd640, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
    };

    localparam logic [W_KBPS-1:0] DTS_KBPS [32] = '{
        12'd32, 12'd56, 12'd64, 12'd96, 12'd112, 12'd128, 12'd192, 12'd224,
        12'd256, 12'd320, 12'd384, 12'd448, 12'd512, 12'd576, 12'd640, 12'd768,
        12'd960, 12'd1024, 12'd1152, 12'd1280, 12'd1344, 12'd1408, 12'd1411,
        12'd1472, 12'd1536, 12'd1920, 12'd2048, 12'd3072, 12'd3840,
        12'd0, 12'd0, 12'd0
    };

    localparam logic [W_KBPS-1:0] MPA_L1_KBPS [16] = '{
        12'd0, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160, 12'd192, 12'd224,
        12'd256, 12'd288, 12'd320, 12'd352, 12'd384, 12'd416, 12'd448, 12'd0
    };

    localparam logic [W_KBPS-1:0] MPA_L2_KBPS [16] = '{
        12'd0, 12'd32, 12'd48, 12'd56, 12'd64, 12'd80, 12'd96, 12'd112,
        12'd128, 12'd160, 12'd192, 12'd224, 12'd256, 12'd320, 12'd384, 12'd0
    };

    localparam logic [W_KBPS-1:0] MPA_L3_V0_KBPS [16] = '{
        12'd0, 12'd8, 12'd16, 12'd24, 12'd32, 12'd64, 12'd80, 12'd56,
        12'd64, 12'd128, 12'd160, 12'd112, 12'd128, 12'd256, 12'd320, 12'd0
    };

    localparam logic [W_KBPS-1:0] MPA_L3_V1_KBPS [16] = '{
        12'd0, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd80, 12'd96,
        12'd112, 12'd128, 12'd160, 12'd192, 12'd224, 12'd256, 12'd320, 12'd0
    };

    function automatic logic [W_KBPS-1:0] mpa_kbps(
        input logic       version,
        input logic [1:0] layer,
        input logic [3:0] code
    );
        logic [W_KBPS-1:0] kbps;
        case (layer)
            2'd1:    kbps = MPA_L1_KBPS[code];
            2'd2:    kbps = MPA_L2_KBPS[code];
            2'd3:    kbps = version ? MPA_L3_V1_KBPS[code] : MPA_L3_V0_KBPS[code];
            default: kbps = '0;
        endcase
        return kbps;
    endfunction

    function automatic t_stream_class classify(
        input logic              is_private,
        input logic [W_BYTE-1:0] id
    );
        t_stream_class cls;
        if (!is_private) begin
            cls = CLS_UNKNOWN;
        end else begin
            case (id) inside
                [8'hE0:8'hEF]: cls = CLS_MPEG_VIDEO;
                [8'hC0:8'hCF]: cls = CLS_MPEG_AUDIO;
                [8'h80:8'h87]: cls = CLS_AC3;
                [8'h88:8'h8F]: cls = CLS_DTS;
                [8'hA0:8'hAF]: cls = CLS_LPCM;
                [8'h20:8'h3F]: cls = CLS_SUBPICTURE;
                default:       cls = CLS_UNKNOWN;
            endcase
        end
        return cls;
    endfunction

endpackage

// File: src/dsabp_in_if.sv
// ----------------------------------------------------------------------------
// Sector byte channel
// Valid/ready channel carrying one sector byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface dsabp_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsabp_pkg::W_BYTE-1:0]  data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/dsabp_out_if.sv
// ----------------------------------------------------------------------------
// Sector result channel
// Valid/ready channel carrying one classification and bitrate per sector.
// ----------------------------------------------------------------------------
interface dsabp_out_if;
    logic                          valid;
    logic                          ready;
    logic [dsabp_pkg::W_CLASS-1:0] stream_class;
    logic [dsabp_pkg::W_BYTE-1:0]  stream_id;
    logic [dsabp_pkg::W_RATE-1:0]  bitrate;
    logic                          bitrate_found;

    modport source (output valid, output stream_class, output stream_id,
                    output bitrate, output bitrate_found, input ready);
    modport sink   (input valid, input stream_class, input stream_id,
                    input bitrate, input bitrate_found, output ready);
endinterface

// File: src/dvd_sector_audio_bitrate_probe.sv
// ----------------------------------------------------------------------------
// DVD sector audio bitrate probe
// Classifies a program-stream sector by private stream sub-id and extracts
// the audio bitrate from the stream headers.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries sector bytes in order from offset zero, one word per byte;
//   last_byte marks the final byte of a sector. o_out carries one word per
//   sector: class, sub-id, bitrate (kbit/s x 1024, DTS x 1000) and a found flag.
//   i_cfg_we/i_cfg_wdata load the bitrate reported for LPCM sectors; write
//   only while no sector is in flight.
// Throughput: one byte per cycle, sustained unless a final byte meets a result
//   stall; set by the single input register feeding the per-byte parse logic.
// Path: the final byte goes from the input register into the result
//   register, which drives o_out; the load waits while the result
//   register still holds an untaken word.
// Reset: clears the parse state and both valid flags; the LPCM rate returns
//   to 2000000.
// Stall: a result word holds on o_out until taken. Non-final bytes keep
//   flowing under a stall; a final byte waits in the input register until
//   the result register frees up, and i_in.ready drops meanwhile.
// ----------------------------------------------------------------------------
module dvd_sector_audio_bitrate_probe #(
    parameter int SECTOR_BYTES = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dsabp_in_if.sink                      i_in,
    dsabp_out_if.source                   o_out,
    input  logic                          i_cfg_we,
    input  logic [dsabp_pkg::W_RATE-1:0]  i_cfg_wdata
);

    localparam int W_POS  = dsabp_pkg::W_POS;
    localparam int W_BYTE = dsabp_pkg::W_BYTE;
    localparam int W_RATE = dsabp_pkg::W_RATE;
    localparam logic [W_POS-1:0] LAST_SYNC_POS = W_POS'(SECTOR_BYTES - 3);

    // input register
    logic                 r_in_valid;
    logic [W_BYTE-1:0]    r_byte;
    logic                 r_last;

    // sector parse state
    logic [W_POS-1:0]     r_pos,       n_pos;
    logic                 r_private,   n_private;
    logic [W_BYTE-1:0]    r_hdr_len,   n_hdr_len;
    logic [W_BYTE-1:0]    r_sub_id,    n_sub_id;
    logic [W_BYTE-1:0]    r_ac3_ptr,   n_ac3_ptr;
    logic [1:0]           r_ac3_sync,  n_ac3_sync;
    logic [5:0]           r_ac3_code,  n_ac3_code;
    logic [4:0]           r_dts_code,  n_dts_code;
    logic                 r_prev_ff,   n_prev_ff;
    dsabp_pkg::t_mpa_stage r_mpa_stage, n_mpa_stage;
    logic [2:0]           r_mpa_vl,    n_mpa_vl;
    logic [3:0]           r_mpa_code,  n_mpa_code;

    logic [W_RATE-1:0]    r_lpcm_rate;

    // result register
    logic                          r_out_valid;
    dsabp_pkg::t_stream_class      r_class;
    logic [W_BYTE-1:0]             r_id;
    logic [W_RATE-1:0]             r_rate;
    logic                          r_found;

    dsabp_pkg::t_stream_class      n_class;
    logic [W_RATE-1:0]             n_rate;
    logic                          n_found;

    logic                 out_free;
    logic                 proc_fire;
    logic [W_POS-1:0]     hdr_len_ext;
    logic [W_POS-1:0]     ac3_sync_pos;

    assign out_free   = !r_out_valid || o_out.ready;
    assign proc_fire  = r_in_valid && (!r_last || out_free);
    assign i_in.ready = !r_in_valid || proc_fire;

    always_comb begin
        n_pos       = (r_pos == dsabp_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
        n_private   = r_private;
        n_hdr_len   = r_hdr_len;
        n_sub_id    = r_sub_id;
        n_ac3_ptr   = r_ac3_ptr;
        n_ac3_sync  = r_ac3_sync;
        n_ac3_code  = r_ac3_code;
        n_dts_code  = r_dts_code;
        n_mpa_stage = r_mpa_stage;
        n_mpa_vl    = r_mpa_vl;
        n_mpa_code  = r_mpa_code;

        if (r_pos == dsabp_pkg::POS_PACK_ID) begin
            n_private = (r_byte == dsabp_pkg::PRIVATE_STREAM_1);
        end
        if (r_pos == dsabp_pkg::POS_HDR_LEN) begin
            n_hdr_len = r_byte;
        end
        hdr_len_ext = W_POS'(n_hdr_len);

        if (r_pos == hdr_len_ext + dsabp_pkg::OFS_SUB_ID) begin
            n_sub_id = r_byte;
        end
        if (r_pos == hdr_len_ext + dsabp_pkg::OFS_AC3_PTR) begin
            n_ac3_ptr = r_byte;
        end
        ac3_sync_pos = hdr_len_ext + W_POS'(n_ac3_ptr) + dsabp_pkg::OFS_AC3_PTR;

        if (r_pos >= hdr_len_ext + dsabp_pkg::OFS_AC3_PTR) begin
            if (r_pos == ac3_sync_pos && r_byte == dsabp_pkg::AC3_SYNC_HI) begin
                n_ac3_sync[0] = 1'b1;
            end
            if (r_pos == ac3_sync_pos + 1'b1 && r_ac3_sync[0]
                    && r_byte == dsabp_pkg::AC3_SYNC_LO) begin
                n_ac3_sync[1] = 1'b1;
            end
            if (r_pos == ac3_sync_pos + dsabp_pkg::AC3_RATE_OFS && (&r_ac3_sync)) begin
                n_ac3_code = r_byte[5:0];
            end
        end

        if (r_pos == hdr_len_ext + dsabp_pkg::OFS_DTS_HI) begin
            n_dts_code = {r_byte[1:0], 3'b000};
        end
        if (r_pos == hdr_len_ext + dsabp_pkg::OFS_DTS_LO) begin
            n_dts_code = {r_dts_code[4:3], r_byte[7:5]};
        end

        case (r_mpa_stage)
            dsabp_pkg::MPA_SEARCH: begin
                if (r_prev_ff && r_byte[7:4] == dsabp_pkg::MPA_SYNC_NIBBLE) begin
                    n_mpa_vl    = r_byte[3:1];
                    n_mpa_stage = dsabp_pkg::MPA_RATE;
                end
            end
            dsabp_pkg::MPA_RATE: begin
                n_mpa_code  = r_byte[7:4];
                n_mpa_stage = dsabp_pkg::MPA_FOUND;
            end
            default: begin
                n_mpa_stage = r_mpa_stage;
            end
        endcase
        n_prev_ff = (r_byte == dsabp_pkg::MPA_SYNC_BYTE)
                 && (r_pos >= dsabp_pkg::POS_PACK_ID) && (r_pos <= LAST_SYNC_POS);

        n_class = dsabp_pkg::classify(n_private, n_sub_id);
        case (n_class)
            dsabp_pkg::CLS_MPEG_AUDIO: begin
                n_rate = (n_mpa_stage == dsabp_pkg::MPA_FOUND)
                       ? {dsabp_pkg::mpa_kbps(n_mpa_vl[2], n_mpa_vl[1:0], n_mpa_code),
                          10'b0}
                       : '0;
            end
            dsabp_pkg::CLS_AC3: begin
                n_rate = (&n_ac3_sync)
                       ? {dsabp_pkg::AC3_KBPS[n_ac3_code[5:1]], 10'b0}
                       : '0;
            end
            dsabp_pkg::CLS_DTS: begin
                n_rate = W_RATE'(dsabp_pkg::DTS_KBPS[n_dts_code])
                       * dsabp_pkg::DTS_KBIT_SCALE;
            end
            dsabp_pkg::CLS_LPCM: begin
                n_rate = r_lpcm_rate;
            end
            default: begin
                n_rate = '0;
            end
        endcase
        n_found = (n_rate != '0)
               && (n_class == dsabp_pkg::CLS_MPEG_AUDIO || n_class == dsabp_pkg::CLS_AC3
                   || n_class == dsabp_pkg::CLS_DTS || n_class == dsabp_pkg::CLS_LPCM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpcm_rate <= dsabp_pkg::LPCM_RATE_RESET;
        end else if (i_cfg_we) begin
            r_lpcm_rate <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc_fire && r_last)) begin
            r_pos       <= '0;
            r_private   <= 1'b0;
            r_hdr_len   <= '0;
            r_sub_id    <= '0;
            r_ac3_ptr   <= '0;
            r_ac3_sync  <= '0;
            r_ac3_code  <= '0;
            r_dts_code  <= '0;
            r_prev_ff   <= 1'b0;
            r_mpa_stage <= dsabp_pkg::MPA_SEARCH;
            r_mpa_vl    <= '0;
            r_mpa_code  <= '0;
        end else if (proc_fire) begin
            r_pos       <= n_pos;
            r_private   <= n_private;
            r_hdr_len   <= n_hdr_len;
            r_sub_id    <= n_sub_id;
            r_ac3_ptr   <= n_ac3_ptr;
            r_ac3_sync  <= n_ac3_sync;
            r_ac3_code  <= n_ac3_code;
            r_dts_code  <= n_dts_code;
            r_prev_ff   <= n_prev_ff;
            r_mpa_stage <= n_mpa_stage;
            r_mpa_vl    <= n_mpa_vl;
            r_mpa_code  <= n_mpa_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_last) begin
            r_class <= n_class;
            r_id    <= n_sub_id;
            r_rate  <= n_rate;
            r_found <= n_found;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.stream_class  = r_class;
    assign o_out.stream_id     = r_id;
    assign o_out.bitrate       = r_rate;
    assign o_out.bitrate_found = r_found;

endmodule

// File: src/dsabp_checker.sv
// ----------------------------------------------------------------------------
// DVD sector audio bitrate probe checker
// Port-level checks on the probe's result channel and input handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "dvd_sector_audio_bitrate_probe_macros.svh"

module dsabp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [dsabp_pkg::W_CLASS-1:0] i_out_class,
    input logic [dsabp_pkg::W_RATE-1:0]  i_out_bitrate,
    input logic                          i_out_found
);

    `DSABP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped under stall")

    `DSABP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid && !(i_in_valid && !i_in_ready && !i_out_valid), "channel not idle after reset")

    `DSABP_ASSERT(a_found_match, i_clk, i_rst_n, i_out_valid |-> (i_out_found == ((i_out_bitrate != '0) && (i_out_class == dsabp_pkg::CLS_MPEG_AUDIO || i_out_class == dsabp_pkg::CLS_AC3 || i_out_class == dsabp_pkg::CLS_DTS || i_out_class == dsabp_pkg::CLS_LPCM))), "found flag disagrees with class and bitrate")

    `DSABP_ASSERT(a_no_rate_class, i_clk, i_rst_n, i_out_valid && (i_out_class == dsabp_pkg::CLS_UNKNOWN || i_out_class == dsabp_pkg::CLS_MPEG_VIDEO || i_out_class == dsabp_pkg::CLS_SUBPICTURE) |-> i_out_bitrate == '0, "bitrate reported for non-audio class")

endmodule

bind dvd_sector_audio_bitrate_probe dsabp_checker u_dsabp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_class   (o_out.stream_class),
    .i_out_bitrate (o_out.bitrate),
    .i_out_found   (o_out.bitrate_found)
);
